### hw/rtl/bli_pkg.sv
// Package for the bounded list block: sizes, command and status codes,
// sequencer state type. No dependencies.
`default_nettype none

package bli_pkg;

	// List capacity and derived widths
	localparam int CAPACITY = 32;
	localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;   // entry index
	localparam int CW       = $clog2(CAPACITY + 1);                   // element count
	localparam int PW       = 6;                                      // position field
	localparam int VW       = 32;                                     // value / element
	localparam int CMPW     = ((CW > PW) ? CW : PW) + 1;              // position compare

	// Stream payload widths
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 3;

	// Command codes
	localparam logic [1:0] CMD_HEAD = 2'd0;
	localparam logic [1:0] CMD_TAIL = 2'd1;
	localparam logic [1:0] CMD_DEL  = 2'd2;

	// Status codes
	localparam logic [1:0] STS_DONE  = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_RANGE = 2'd2;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_EMIT
	} bli_state_t;

endpackage

`default_nettype wire

### hw/rtl/bounded_list_insert_delete.sv
// Bounded ordered list: insert at head or tail, delete by position, list dump per command.
// Circular buffer in a single-port-write memory, one shared wrap-around index adder.
// Depends on bli_pkg.
//
// A delete before the tail closes the gap by moving each later entry one place toward the head,
//   each move a read then a write, the reads going through the memory's single read port.
// Output stalls hold the dump, and the sequencer with it.
// A new command is taken once the final element read has reached the output register.
// Reset: count, head pointer, sequencer and output valid clear; the entries are not cleared.
`default_nettype none

module bounded_list_insert_delete (
	input  wire                          clk,
	input  wire                          arst_n,
	// command in
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [bli_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] value, [37:32] position, zero pad
	input  wire  [bli_pkg::S_TUSER_W-1:0] s_tuser,   // [1:0] command
	// list elements out
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [bli_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] element
	output logic                         m_tlast,   // is_last
	output logic [bli_pkg::M_TUSER_W-1:0] m_tuser    // [0] list_empty, [2:1] status
);
	import bli_pkg::*;

	// Input fields
	logic [1:0]           cmd;
	logic signed [VW-1:0] value;
	logic [PW-1:0]        position;
	assign cmd      = s_tuser[1:0];
	assign value    = s_tdata[VW-1:0];
	assign position = s_tdata[VW+PW-1:VW];

	// Control state
	bli_state_t    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [CW-1:0] k_q, k_d;
	logic [1:0]    status_q, status_d;

	// Memory and read register
	logic signed [VW-1:0] mem [CAPACITY];
	logic signed [VW-1:0] rdata_q;
	logic signed [VW-1:0] wdata;
	logic                 mem_we, rd_en;

	// Read stage and output register
	logic s1_valid_q, s1_last_q, s1_empty_q;
	logic s1_load, s1_last_d, s1_empty_d;
	logic m_valid_q, m_last_q, m_empty_q;
	logic signed [VW-1:0] m_elem_q;
	logic [1:0]    m_status_q;
	logic          adv;

	// Shared index unit: (head + offset) modulo CAPACITY
	logic [AW-1:0] unit_b, unit_addr;
	logic [AW:0]   unit_sum;
	assign unit_sum  = {1'b0, head_q} + {1'b0, unit_b};
	assign unit_addr = (unit_sum >= (AW+1)'(CAPACITY))
		? AW'(unit_sum - (AW+1)'(CAPACITY)) : unit_sum[AW-1:0];

	logic            s_acc;
	logic [CMPW-1:0] pos_ext, cnt_ext;
	assign adv      = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && !s1_valid_q;
	assign s_acc    = s_tvalid && s_tready;
	assign pos_ext  = CMPW'(position);
	assign cnt_ext  = CMPW'(count_q);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and datapath control
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		head_d     = head_q;
		idx_d      = idx_q;
		k_d        = k_q;
		status_d   = status_q;
		unit_b     = '0;
		mem_we     = 1'b0;
		wdata      = value;
		rd_en      = 1'b0;
		s1_load    = 1'b0;
		s1_last_d  = 1'b0;
		s1_empty_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					k_d      = '0;
					status_d = STS_DONE;
					state_d  = ST_EMIT;
					case (cmd)
						CMD_HEAD, CMD_TAIL: begin
							if (count_q >= CW'(CAPACITY)) begin
								status_d = STS_FULL;
							end else begin
								unit_b  = (cmd == CMD_HEAD) ? AW'(CAPACITY - 1) : count_q[AW-1:0];
								mem_we  = 1'b1;
								count_d = count_q + CW'(1);
								if (cmd == CMD_HEAD) begin
									head_d = unit_addr;
								end
							end
						end
						CMD_DEL: begin
							if (pos_ext >= cnt_ext) begin
								status_d = STS_RANGE;
							end else begin
								idx_d = AW'(position);
								if (pos_ext + CMPW'(1) == cnt_ext) begin
									count_d = count_q - CW'(1);
								end else begin
									state_d = ST_MOVE_RD;
								end
							end
						end
						default: ;
					endcase
				end
			end
			// close the gap: fetch entry idx+1
			ST_MOVE_RD: begin
				unit_b  = idx_q + AW'(1);
				rd_en   = 1'b1;
				state_d = ST_MOVE_WR;
			end
			// ... and write it to entry idx
			ST_MOVE_WR: begin
				unit_b = idx_q;
				mem_we = 1'b1;
				wdata  = rdata_q;
				idx_d  = idx_q + AW'(1);
				if ((CW+1)'(idx_q) + (CW+1)'(2) == {1'b0, count_q}) begin
					count_d = count_q - CW'(1);
					state_d = ST_EMIT;
				end else begin
					state_d = ST_MOVE_RD;
				end
			end
			// dump the list head to tail, one read per cycle while the output can advance
			ST_EMIT: begin
				if (adv) begin
					s1_load = 1'b1;
					if (count_q == '0) begin
						s1_empty_d = 1'b1;
						s1_last_d  = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						unit_b    = k_q[AW-1:0];
						rd_en     = 1'b1;
						s1_last_d = (k_q + CW'(1) == count_q);
						k_d       = k_q + CW'(1);
						if (s1_last_d) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			head_q   <= '0;
			idx_q    <= '0;
			k_q      <= '0;
			status_q <= STS_DONE;
		end else begin
			count_q  <= count_d;
			head_q   <= head_d;
			idx_q    <= idx_d;
			k_q      <= k_d;
			status_q <= status_d;
		end
	end

	// Entry memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[unit_addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[unit_addr];
		end
	end

	// Read stage flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_last_q  <= 1'b0;
			s1_empty_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= s1_load;
			s1_last_q  <= s1_last_d;
			s1_empty_q <= s1_empty_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_elem_q   <= s1_empty_q ? '0 : rdata_q;
			m_last_q   <= s1_last_q;
			m_empty_q  <= s1_empty_q;
			m_status_q <= status_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_TDATA_W'(m_elem_q);
	assign m_tlast  = m_last_q;
	assign m_tuser  = {m_status_q, m_empty_q};

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list count beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (count_q == $past(count_q) + CW'(1)
			|| count_q + CW'(1) == $past(count_q)))
		else $error("count moved by more than one");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && (cmd == CMD_HEAD || cmd == CMD_TAIL) && count_q == CW'(CAPACITY))
		|=> $stable(count_q) && status_q == STS_FULL)
		else $error("insert into full list changed the list");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_empty_q) |-> (m_last_q && m_elem_q == '0))
		else $error("empty result not last or not zero");

endmodule

`default_nettype wire

### sim/bounded_list_insert_delete_tb.sv
// Self-checking testbench for bounded_list_insert_delete: command stream in, list dump out.
// A queue-based shadow list predicts every dump; depends on bli_pkg and the block's RTL.
`default_nettype none

module bounded_list_insert_delete_tb;
	import bli_pkg::*;

	localparam int          HALF_PERIOD = 6;
	localparam int          IDLE_LIMIT  = 4000;
	localparam int          HOLD_CYCLES = 300;
	localparam logic [1:0]  CMD_NONE    = 2'd3;    // unused code, list left alone

	// one expected list element, as it leaves the block
	typedef struct packed {
		logic [VW-1:0] element;
		logic          last;
		logic          empty;
		logic [1:0]    status;
	} elem_result_t;

	// directed row: command, and where obvious the status and length afterwards
	typedef struct packed {
		logic [1:0]    cmd;
		logic [VW-1:0] val;
		logic [PW-1:0] pos;
		logic          typed;
		logic [1:0]    t_status;
		logic [6:0]    t_count;
	} dir_row_t;

	localparam int NDIR = 20;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // [31:0] value, [37:32] position, zero pad
	logic [S_TUSER_W-1:0] s_tuser;   // [1:0] command
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // [31:0] element
	logic m_tlast;
	logic [M_TUSER_W-1:0] m_tuser;   // [0] list_empty, [2:1] status

	logic signed [VW-1:0] shadow_list [$];
	elem_result_t         pending_results [$];
	int                   errors = 0;
	int                   burst_left = 0;
	bit                   hold_req = 1'b0;

	dir_row_t script [NDIR] = '{
		'{CMD_DEL,  32'h0000_0000, 6'd0,  1'b1, STS_RANGE, 7'd0},   // delete on empty list
		'{CMD_NONE, 32'hFFFF_FFFF, 6'd63, 1'b1, STS_DONE,  7'd0},   // unused code, empty
		'{CMD_HEAD, 32'h7FFF_FFFF, 6'd0,  1'b1, STS_DONE,  7'd1},
		'{CMD_TAIL, 32'h8000_0000, 6'd0,  1'b1, STS_DONE,  7'd2},
		'{CMD_HEAD, 32'hFFFF_FFFF, 6'd0,  1'b1, STS_DONE,  7'd3},
		'{CMD_TAIL, 32'h0000_0000, 6'd63, 1'b1, STS_DONE,  7'd4},
		'{CMD_HEAD, 32'h0000_0001, 6'd63, 1'b1, STS_DONE,  7'd5},   // position ignored
		'{CMD_DEL,  32'hFFFF_FFFF, 6'd63, 1'b1, STS_RANGE, 7'd5},   // far out of range
		'{CMD_DEL,  32'h0000_0000, 6'd5,  1'b1, STS_RANGE, 7'd5},   // exactly at count
		'{CMD_DEL,  32'h0000_0000, 6'd4,  1'b1, STS_DONE,  7'd4},   // tail
		'{CMD_DEL,  32'h1234_5678, 6'd0,  1'b1, STS_DONE,  7'd3},   // head
		'{CMD_NONE, 32'h5A5A_A5A5, 6'd21, 1'b1, STS_DONE,  7'd3},   // unused code, non-empty
		'{CMD_DEL,  32'h0000_0000, 6'd1,  1'b1, STS_DONE,  7'd2},   // middle
		'{CMD_TAIL, 32'hAAAA_AAAA, 6'd42, 1'b0, STS_DONE,  7'd0},
		'{CMD_HEAD, 32'h5555_5555, 6'd21, 1'b0, STS_DONE,  7'd0},
		'{CMD_DEL,  32'h0000_0000, 6'd2,  1'b0, STS_DONE,  7'd0},
		'{CMD_DEL,  32'h0000_0000, 6'd0,  1'b0, STS_DONE,  7'd0},
		'{CMD_DEL,  32'h0000_0000, 6'd0,  1'b0, STS_DONE,  7'd0},
		'{CMD_DEL,  32'h0000_0000, 6'd0,  1'b1, STS_DONE,  7'd0},   // last one out
		'{CMD_DEL,  32'h0000_0000, 6'd0,  1'b1, STS_RANGE, 7'd0}
	};

	bounded_list_insert_delete i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// shadow list update and expected dump for one accepted command
	task automatic list_apply(input logic [1:0] cmd, input logic [VW-1:0] val,
			input logic [PW-1:0] pos, output logic [1:0] st);
		int k;
		st = STS_DONE;
		case (cmd)
			CMD_HEAD, CMD_TAIL: begin
				if (shadow_list.size() >= CAPACITY)
					st = STS_FULL;
				else if (cmd == CMD_HEAD)
					shadow_list.push_front(val);
				else
					shadow_list.push_back(val);
			end
			CMD_DEL: begin
				if (int'(pos) >= shadow_list.size())
					st = STS_RANGE;
				else
					shadow_list.delete(int'(pos));
			end
			default: ;
		endcase
		if (shadow_list.size() == 0)
			pending_results.push_back('{'0, 1'b1, 1'b1, st});
		else
			for (k = 0; k < shadow_list.size(); k++)
				pending_results.push_back('{shadow_list[k], k == shadow_list.size() - 1,
					1'b0, st});
	endtask

	// offer one command and hold it until the transaction completes
	task automatic send_command(input logic [1:0] cmd, input logic [VW-1:0] val,
			input logic [PW-1:0] pos, output logic [1:0] st);
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, pos, val};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		list_apply(cmd, val, pos, st);
	endtask

	// bursts of back-to-back commands, random gaps between bursts
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 6);
		end
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [VW-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// mostly valid positions, some anywhere in the field
	function automatic logic [PW-1:0] rand_position();
		if (shadow_list.size() > 0 && $urandom_range(0, 4) != 0)
			return PW'($urandom_range(0, shadow_list.size() - 1));
		return PW'($urandom_range(0, 63));
	endfunction

	task automatic random_mixed(input int n);
		int i;
		int r;
		logic [1:0] cmd;
		logic [1:0] st;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			cmd = (r < 38) ? CMD_HEAD : (r < 68) ? CMD_TAIL : (r < 95) ? CMD_DEL : CMD_NONE;
			send_command(cmd, rand_value(), rand_position(), st);
			pace_sender();
		end
	endtask

	// output side: compare every element transaction with the oldest expectation
	always @(posedge clk) begin
		elem_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected element %h", m_tdata));
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tdata != exp_r.element)
					report_mismatch($sformatf("element %h, want %h", m_tdata, exp_r.element));
				if (m_tlast != exp_r.last)
					report_mismatch($sformatf("last %b, want %b", m_tlast, exp_r.last));
				if (m_tuser[0] != exp_r.empty)
					report_mismatch($sformatf("empty %b, want %b", m_tuser[0], exp_r.empty));
				if (m_tuser[2:1] != exp_r.status)
					report_mismatch($sformatf("status %0d, want %0d", m_tuser[2:1],
						exp_r.status));
			end
		end
	end

	// receiver: pacing modes of its own, plus a long hold-off on request
	initial begin : sink_pacing
		int mode;
		int left;
		int held;
		m_tready = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 120);
				end
				left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= (left % 4 != 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// watchdog: too long without any transaction on either side
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("FAIL");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int i;
		logic [1:0] st;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < NDIR; i++) begin
			send_command(script[i].cmd, script[i].val, script[i].pos, st);
			if (script[i].typed && (st != script[i].t_status
					|| shadow_list.size() != int'(script[i].t_count)))
				report_mismatch($sformatf("row %0d: status %0d length %0d", i, st,
					shadow_list.size()));
			pace_sender();
		end

		random_mixed(20);

		// sender pauses until the last dump is out
		s_tvalid <= 1'b0;
		wait_drained();
		@(posedge clk);

		// receiver holds off while commands keep coming; fill to full and beyond
		hold_req = 1'b1;
		while (shadow_list.size() < CAPACITY)
			send_command($urandom_range(0, 1) ? CMD_HEAD : CMD_TAIL, rand_value(),
				PW'($urandom_range(0, 63)), st);
		for (i = 0; i < 4; i++)
			send_command($urandom_range(0, 1) ? CMD_HEAD : CMD_TAIL, rand_value(),
				PW'($urandom_range(0, 63)), st);
		pace_sender();

		// churn around full
		random_mixed(4);

		// drain with valid and out-of-range deletes, then a couple on the empty list
		while (shadow_list.size() > 0) begin
			if ($urandom_range(0, 4) == 0)
				send_command(CMD_DEL, rand_value(),
					PW'($urandom_range(shadow_list.size(), 63)), st);
			else
				send_command(CMD_DEL, rand_value(),
					PW'($urandom_range(0, shadow_list.size() - 1)), st);
			pace_sender();
		end
		for (i = 0; i < 2; i++) begin
			send_command(CMD_DEL, rand_value(), PW'($urandom_range(0, 63)), st);
			pace_sender();
		end

		random_mixed(6);

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d elements never arrived", pending_results.size()));
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
